// File: rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lkvc_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_ERASE  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key;
    logic [31:0] price;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value;
    logic        evicted;
    logic [63:0] evicted_key;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_PLAN,
    ST_UPDATE,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic scan_start;
    logic scan_step;
    logic plan;
    logic upd_start;
    logic upd_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic scan_last;
  } sts_t;

endpackage
`default_nettype wire

// File: rtl/lkvc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module lkvc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/lkvc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module lkvc_datapath #(
  parameter int Entries = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [8:0]       capacity_i,
  input  wire lkvc_pkg::req_t   req_i,
  input  wire lkvc_pkg::cmd_t   cmd_i,
  output lkvc_pkg::sts_t        sts_o,
  output lkvc_pkg::rsp_t        rsp_o
);

  localparam int Aw = $clog2(Entries);
  localparam int Cw = $clog2(Entries + 1);

  // The valid mark and the recency rank of each entry share one memory word,
  // which a clearing pass zeroes after reset.
  logic [Cw-1:0]      occ_q, occ_d;
  lkvc_pkg::req_t     req_q;

  // Address counter shared by the find pass and the update pass. The read
  // address runs one entry ahead of the data handled in that cycle.
  logic [Aw-1:0] raddr_q, raddr_d;
  logic [Aw-1:0] idx_q, idx_d;
  logic          pend_q, pend_d;

  logic [63:0] key_rd;
  logic [31:0] val_rd;
  logic [Aw:0] meta_rd;
  logic [Aw-1:0] age_rd;
  logic          v_rd;

  // Results of the find pass.
  logic          found_q, found_d;
  logic [Aw-1:0] slot_q, slot_d;
  logic [Aw-1:0] sage_q, sage_d;
  logic [31:0]   sval_q, sval_d;
  logic          old_q, old_d;
  logic [Aw-1:0] oslot_q, oslot_d;
  logic [Aw-1:0] oage_q, oage_d;
  logic [63:0]   okey_q, okey_d;
  logic          free_q, free_d;
  logic [Aw-1:0] fslot_q, fslot_d;

  // Decisions taken in the plan step.
  logic          ev_q, ev_d;
  logic [Aw-1:0] tgt_q, tgt_d;

  logic          key_we, val_we, age_we;
  logic [Aw-1:0] key_wa, val_wa, age_wa;
  logic [63:0]   key_wd;
  logic [31:0]   val_wd;
  logic [Aw:0]   age_wd;

  lkvc_pkg::rsp_t rsp_q, rsp_d;

  lkvc_ram #(.Width(64), .Depth(Entries)) u_key (
    .clk_i, .we_i(key_we), .waddr_i(key_wa), .wdata_i(key_wd),
    .raddr_i(raddr_q), .rdata_o(key_rd)
  );
  lkvc_ram #(.Width(32), .Depth(Entries)) u_val (
    .clk_i, .we_i(val_we), .waddr_i(val_wa), .wdata_i(val_wd),
    .raddr_i(raddr_q), .rdata_o(val_rd)
  );
  lkvc_ram #(.Width(Aw + 1), .Depth(Entries)) u_age (
    .clk_i, .we_i(age_we), .waddr_i(age_wa), .wdata_i(age_wd),
    .raddr_i(raddr_q), .rdata_o(meta_rd)
  );

  assign v_rd   = meta_rd[Aw];
  assign age_rd = meta_rd[Aw-1:0];

  logic [Cw-1:0] cap_eff;
  logic          last_addr;

  // Clamp capacity into one to Entries.
  always_comb begin
    if (capacity_i == 9'd0) begin
      cap_eff = Cw'(1);
    end else if ({{Cw{1'b0}}, capacity_i} > (Cw + 9)'(Entries)) begin
      cap_eff = Cw'(Entries);
    end else begin
      cap_eff = Cw'(capacity_i);
    end
  end

  assign last_addr        = (raddr_q == Aw'(Entries - 1));
  assign sts_o.scan_last  = pend_q && (idx_q == Aw'(Entries - 1));
  assign sts_o.clear_last = last_addr;

  // Pass control, match search, outcome planning, age update and store writes.
  always_comb begin
    logic v;
    logic ve;
    logic nv;
    logic [Aw-1:0] na;
    raddr_d = raddr_q;
    idx_d   = idx_q;
    pend_d  = 1'b0;
    found_d = found_q; slot_d = slot_q; sage_d = sage_q; sval_d = sval_q;
    old_d   = old_q; oslot_d = oslot_q; oage_d = oage_q; okey_d = okey_q;
    free_d  = free_q; fslot_d = fslot_q;
    ev_d    = ev_q; tgt_d = tgt_q;
    occ_d   = occ_q;
    rsp_d   = rsp_q;
    key_we = 1'b0; val_we = 1'b0; age_we = 1'b0;
    key_wa = tgt_q; val_wa = idx_q; age_wa = idx_q;
    key_wd = req_q.key; val_wd = req_q.price; age_wd = meta_rd;
    v  = v_rd;
    // An entry evicted in the plan step no longer counts as valid.
    ve = v_rd && !(ev_q && idx_q == oslot_q);
    nv = ve;
    na = age_rd;

    if (cmd_i.clear) begin
      // Clearing pass after reset, one entry a cycle.
      age_we = 1'b1;
      age_wa = raddr_q;
      age_wd = '0;
      if (!last_addr) begin
        raddr_d = raddr_q + Aw'(1);
      end
    end else if (cmd_i.scan_start || cmd_i.upd_start) begin
      raddr_d = '0;
      pend_d  = 1'b0;
      if (cmd_i.scan_start) begin
        found_d = 1'b0; old_d = 1'b0; free_d = 1'b0;
      end
    end else if (cmd_i.scan_step || cmd_i.upd_step) begin
      // Read data for idx arrives this cycle; issue the next address.
      pend_d = !(pend_q && idx_q == Aw'(Entries - 1));
      idx_d  = raddr_q;
      if (!last_addr) begin
        raddr_d = raddr_q + Aw'(1);
      end
      if (pend_q && idx_q == Aw'(Entries - 1)) begin
        pend_d = 1'b0;
      end
    end

    if (cmd_i.scan_step && pend_q) begin
      if (v && key_rd == req_q.key && !found_q) begin
        found_d = 1'b1; slot_d = idx_q; sage_d = age_rd; sval_d = val_rd;
      end
      if (v && (!old_q || age_rd > oage_q)) begin
        old_d = 1'b1; oslot_d = idx_q; oage_d = age_rd; okey_d = key_rd;
      end
      if (!v && !free_q) begin
        free_d = 1'b1; fslot_d = idx_q;
      end
    end

    // Decide the outcome before touching the store.
    if (cmd_i.plan) begin
      rsp_d = '0;
      ev_d  = 1'b0;
      unique case (lkvc_pkg::op_e'(req_q.operation))
        lkvc_pkg::OP_LOOKUP: begin
          rsp_d.hit   = found_q;
          rsp_d.value = found_q ? sval_q : 32'd0;
        end
        lkvc_pkg::OP_INSERT: begin
          rsp_d.hit = found_q;
          if (found_q) begin
            tgt_d = slot_q;
          end else if (occ_q >= cap_eff && occ_q != '0 && old_q) begin
            ev_d  = 1'b1;
            tgt_d = free_q && fslot_q < oslot_q ? fslot_q : oslot_q;
            rsp_d.evicted     = 1'b1;
            rsp_d.evicted_key = okey_q;
            occ_d = occ_q - Cw'(1);
          end else begin
            tgt_d = fslot_q;
          end
        end
        lkvc_pkg::OP_ERASE: begin
          rsp_d.hit = found_q;
        end
        default: begin
        end
      endcase
    end

    // Age and valid update pass, one entry a cycle.
    if (cmd_i.upd_step && pend_q) begin
      age_we = 1'b1;
      unique case (lkvc_pkg::op_e'(req_q.operation))
        lkvc_pkg::OP_LOOKUP: begin
          if (found_q && ve) begin
            if (idx_q == slot_q) na = '0;
            else if (age_rd < sage_q) na = age_rd + Aw'(1);
          end
        end
        lkvc_pkg::OP_INSERT: begin
          if (found_q) begin
            if (ve) begin
              if (idx_q == slot_q) na = '0;
              else if (age_rd < sage_q) na = age_rd + Aw'(1);
            end
          end else if (idx_q == tgt_q) begin
            na = '0;
            nv = 1'b1;
          end else if (ve) begin
            na = age_rd + Aw'(1);
          end
        end
        lkvc_pkg::OP_ERASE: begin
          if (found_q && ve) begin
            if (idx_q == slot_q) begin
              na = '0;
              nv = 1'b0;
            end else if (age_rd > sage_q) begin
              na = age_rd - Aw'(1);
            end
          end
        end
        default: begin
        end
      endcase
      age_wd = {nv, na};
    end

    // Key, price and occupancy change once the ages are done.
    if (cmd_i.out_load) begin
      unique case (lkvc_pkg::op_e'(req_q.operation))
        lkvc_pkg::OP_INSERT: begin
          val_we = 1'b1; val_wa = tgt_q;
          if (!found_q) begin
            key_we = 1'b1;
            occ_d = occ_q + Cw'(1);
          end
        end
        lkvc_pkg::OP_ERASE: begin
          if (found_q) begin
            occ_d = occ_q - Cw'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state and pass counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      pend_q  <= 1'b0;
      raddr_q <= '0;
      idx_q   <= '0;
    end else begin
      occ_q   <= occ_d;
      pend_q  <= pend_d;
      raddr_q <= raddr_d;
      idx_q   <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    found_q <= found_d; slot_q <= slot_d; sage_q <= sage_d; sval_q <= sval_d;
    old_q <= old_d; oslot_q <= oslot_d; oage_q <= oage_d; okey_q <= okey_d;
    free_q <= free_d; fslot_q <= fslot_d;
    ev_q <= ev_d; tgt_q <= tgt_d;
    rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;

endmodule
`default_nettype wire

// File: rtl/lkvc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lkvc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire lkvc_pkg::sts_t sts_i,
  output lkvc_pkg::cmd_t      cmd_o
);

  lkvc_pkg::state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkvc_pkg::ST_CLEAR:  if (sts_i.clear_last) state_d = lkvc_pkg::ST_IDLE;
      lkvc_pkg::ST_IDLE:   if (in_valid_i) state_d = lkvc_pkg::ST_FIND;
      lkvc_pkg::ST_FIND:   if (sts_i.scan_last) state_d = lkvc_pkg::ST_PLAN;
      lkvc_pkg::ST_PLAN:   state_d = lkvc_pkg::ST_UPDATE;
      lkvc_pkg::ST_UPDATE: if (sts_i.scan_last) state_d = lkvc_pkg::ST_DONE;
      lkvc_pkg::ST_DONE:   if (!out_stall_i) state_d = lkvc_pkg::ST_IDLE;
      default:             state_d = lkvc_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      lkvc_pkg::ST_CLEAR:  cmd_o.clear = 1'b1;
      lkvc_pkg::ST_IDLE: begin
        in_stall_o       = 1'b0;
        cmd_o.load       = in_valid_i;
        cmd_o.scan_start = in_valid_i;
      end
      lkvc_pkg::ST_FIND:   cmd_o.scan_step = 1'b1;
      lkvc_pkg::ST_PLAN: begin
        cmd_o.plan      = 1'b1;
        cmd_o.upd_start = 1'b1;
      end
      lkvc_pkg::ST_UPDATE: begin
        cmd_o.upd_step = 1'b1;
        cmd_o.out_load = sts_i.scan_last;
      end
      lkvc_pkg::ST_DONE:   out_valid_o = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkvc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// Fully associative LRU key/price store. Each request (lookup, insert or
// erase) passes through these steps from one input transfer to the next:
// acceptance, a pass over the store's memory port to find the key, the
// least recent entry and a free slot, a planning step, a second pass that
// rewrites every recency rank and valid mark, and a state that holds the
// result until its transfer. One request is handled at a time. After reset
// the input is stalled while the valid marks are cleared. The user must
// write capacity only while the block is idle, which it does not enforce.
module lru_key_value_cache #(
  parameter int ENTRIES = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [8:0]     cfg_wdata_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire lkvc_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output lkvc_pkg::rsp_t      out_data_o
);

  logic [8:0]     capacity_q;
  lkvc_pkg::cmd_t cmd;
  lkvc_pkg::sts_t sts;

  // Capacity register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 9'd200;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  lkvc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  lkvc_datapath #(.Entries(ENTRIES)) u_dp (
    .clk_i, .rst_ni, .capacity_i(capacity_q), .req_i(in_data_i),
    .cmd_i(cmd), .sts_o(sts), .rsp_o(out_data_o)
  );

endmodule
`default_nettype wire
